>>> design/hlm_pkg.sv
// Shared types and constants of the Huber loss block.
package hlm_pkg;

  localparam int DATA_W            = 16;
  localparam int DIFF_W            = 17;
  localparam int DELTA_W           = 15;
  localparam int LOSS_W            = 32;
  localparam int SUM_W             = 49;
  localparam int QUO_W             = 32;
  localparam int ITER_W            = $clog2(QUO_W);
  localparam int FIFO_DEPTH        = 4;
  localparam int MAX_ITEMS_DEFAULT = 65536;

  localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(256);

  // One classified pair on its way from the front to the back.
  typedef struct packed {
    logic [LOSS_W-1:0]        loss;
    logic signed [DATA_W-1:0] clip;
    logic                     last;
  } hlm_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } hlm_state_t;

endpackage

>>> design/hlm_front.sv
// Front: takes pairs, forms the difference, clip and element loss.
module hlm_front
  import hlm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [DELTA_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [DATA_W-1:0]  predicted,
  input  logic signed [DATA_W-1:0]  target,
  input  logic                      last_item,
  output logic                      item_valid,
  input  logic                      item_ready,
  output hlm_item_t                 item
);

  logic [DELTA_W-1:0]        huber_delta;
  logic                      s1_valid;
  logic [DATA_W-1:0]         s1_opa;
  logic [DIFF_W-1:0]         s1_opb;
  logic signed [DATA_W-1:0]  s1_clip;
  logic                      s1_last;

  logic signed [DIFF_W-1:0]  diff;
  logic [DATA_W-1:0]         mag;
  logic [DATA_W-1:0]         dd;
  logic                      small_diff;
  logic [DATA_W-1:0]         opa;
  logic [DIFF_W-1:0]         opb;
  logic signed [DATA_W-1:0]  clip;
  logic [2*DIFF_W-1:0]       product;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      huber_delta <= DELTA_RESET;
    end else if (cfg_valid) begin
      huber_delta <= cfg_data;
    end
  end

  always_comb begin
    diff       = DIFF_W'(predicted) - DIFF_W'(target);
    mag        = diff[DIFF_W-1] ? DATA_W'(-diff) : diff[DATA_W-1:0];
    dd         = {1'b0, huber_delta};
    small_diff = (mag <= dd);
    // Outside the quadratic zone the loss is delta * (2|v| - delta).
    opa        = small_diff ? mag : dd;
    opb        = small_diff ? {1'b0, mag} : ({mag, 1'b0} - {1'b0, dd});
    if (small_diff) begin
      clip = diff[DATA_W-1:0];
    end else if (diff[DIFF_W-1]) begin
      clip = -$signed(dd);
    end else begin
      clip = $signed(dd);
    end
  end

  assign in_ready = !s1_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opa  <= opa;
      s1_opb  <= opb;
      s1_clip <= clip;
      s1_last <= last_item;
    end
  end

  assign product    = {{(DIFF_W-DATA_W){1'b0}}, s1_opa} * s1_opb;
  assign item_valid = s1_valid;
  assign item.loss  = product[LOSS_W-1:0];
  assign item.clip  = s1_clip;
  assign item.last  = s1_last;

endmodule

>>> design/hlm_fifo.sv
// Short queue of classified pairs between front and back.
module hlm_fifo
  import hlm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  hlm_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output hlm_item_t rd_item
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  hlm_item_t        slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign wr_ready = (fill != CNT_W'(FIFO_DEPTH));
  assign rd_valid = (fill != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

>>> design/hlm_back.sv
// Back: run accumulation, mean divider and output register.
module hlm_back
  import hlm_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hlm_item_t                 in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [LOSS_W-1:0]         element_loss,
  output logic signed [DATA_W-1:0]  clipped_diff,
  output logic [QUO_W-1:0]          mean_loss,
  output logic                      run_end,
  output logic                      run_too_long
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0]  MaxCnt   = CNT_W'(MAX_ITEMS);
  localparam logic [ITER_W-1:0] IterLast = ITER_W'(QUO_W - 1);

  hlm_state_t state, state_next;

  logic [SUM_W-1:0]  loss_sum;
  logic [CNT_W-1:0]  pair_count;
  logic              overflow_seen;

  logic [ITER_W-1:0] iter;
  logic [CNT_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [CNT_W-1:0]  divisor;
  logic [LOSS_W-1:0] pend_loss;
  logic [DATA_W-1:0] pend_clip;
  logic              pend_ovf;

  logic              slot_free;
  logic              pop;
  logic              div_done;
  logic              room;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  count_next;
  logic              ovf_next;
  logic [CNT_W:0]    trial;
  logic              ge;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop && in_item.last) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    slot_free = !out_valid || out_ready;
    pop       = 1'b0;
    div_done  = 1'b0;
    unique case (state)
      ST_IDLE:   pop = in_valid && slot_free;
      ST_DIVIDE: div_done = (iter == IterLast);
      default: begin
        pop      = 1'b0;
        div_done = 1'b0;
      end
    endcase
  end

  assign in_ready = pop;

  always_comb begin
    room       = (pair_count < MaxCnt);
    sum_add    = {1'b0, loss_sum} + (SUM_W+1)'(in_item.loss);
    sum_next   = loss_sum;
    count_next = pair_count;
    if (room) begin
      sum_next   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      count_next = pair_count + 1'b1;
    end
    ovf_next = overflow_seen || !room;
  end

  // One quotient bit per cycle, restoring.
  always_comb begin
    trial = {rem, quo[QUO_W-1]};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      loss_sum      <= '0;
      pair_count    <= '0;
      overflow_seen <= 1'b0;
      iter          <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        if (in_item.last) begin
          loss_sum      <= '0;
          pair_count    <= '0;
          overflow_seen <= 1'b0;
        end else begin
          loss_sum      <= sum_next;
          pair_count    <= count_next;
          overflow_seen <= ovf_next;
        end
      end
      if (state == ST_DIVIDE) begin
        iter <= iter + 1'b1;
      end else begin
        iter <= '0;
      end
    end
  end

  // The quotient stays below 2^32, so the high sum bits are below the count.
  always_ff @(posedge clk) begin
    if (pop && in_item.last) begin
      rem       <= CNT_W'(sum_next[SUM_W-1:QUO_W]);
      quo       <= sum_next[QUO_W-1:0];
      divisor   <= count_next;
      pend_loss <= in_item.loss;
      pend_clip <= in_item.clip;
      pend_ovf  <= ovf_next;
    end else if (state == ST_DIVIDE) begin
      rem <= ge ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((pop && !in_item.last) || div_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !in_item.last) begin
      element_loss <= in_item.loss;
      clipped_diff <= in_item.clip;
      mean_loss    <= '0;
      run_end      <= 1'b0;
      run_too_long <= ovf_next;
    end else if (div_done) begin
      element_loss <= pend_loss;
      clipped_diff <= pend_clip;
      mean_loss    <= {quo[QUO_W-2:0], ge};
      run_end      <= 1'b1;
      run_too_long <= pend_ovf;
    end
  end

endmodule

>>> design/huber_loss_mean.sv
// Top level of the streaming Huber loss with per-run mean.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | tdata predicted, target; tlast last_item
//  m_axis   | out       | tdata element_loss, clipped_diff, mean_loss;
//           |           | tlast run_end; tuser run_too_long
//  cfg      | in        | data huber_delta, always ready
//
// A pair not closing a run passes the front stage, a queue slot and the
// output register in turn; one pair per cycle is sustained while m_axis is
// ready and no run is closing. A closing pair holds the back while the mean
// divider makes one quotient bit per cycle over 32 bits. The front keeps
// taking pairs until the 4-entry queue and its own stage are full.
// Reset clears the run sums, the queue and sets delta to 256 (1.0 with 8 fraction bits).
// A stalled m_axis holds the output register; the back then stops popping.
module huber_loss_mean
  import hlm_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [DELTA_W-1:0] cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // predicted[15:0], target[31:16]
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // element_loss[31:0], clipped_diff[47:32], mean_loss[79:48]
  output logic [79:0]        m_axis_tdata,
  output logic               m_axis_tlast,
  output logic               m_axis_tuser    // run_too_long
);

  logic      f_valid;
  logic      f_ready;
  hlm_item_t f_item;
  logic      q_valid;
  logic      q_ready;
  hlm_item_t q_item;

  logic [LOSS_W-1:0]        element_loss;
  logic signed [DATA_W-1:0] clipped_diff;
  logic [QUO_W-1:0]         mean_loss;

  hlm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .predicted  (s_axis_tdata[15:0]),
    .target     (s_axis_tdata[31:16]),
    .last_item  (s_axis_tlast),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  hlm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  hlm_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_item      (q_item),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .element_loss (element_loss),
    .clipped_diff (clipped_diff),
    .mean_loss    (mean_loss),
    .run_end      (m_axis_tlast),
    .run_too_long (m_axis_tuser)
  );

  assign m_axis_tdata = {mean_loss, clipped_diff, element_loss};

endmodule
